@@ rtl/core/thai_sb_pkg.sv @@
// Package for the Thai syllable breaker: field widths, Thai codepoint
// constants, category masks, state and result-kind types, decision struct.
// No dependencies.
package thai_sb_pkg;

    localparam int unsigned CP_W                   = 21;
    localparam int unsigned LEN_W                  = 3;
    localparam int unsigned KIND_W                 = 2;
    localparam int unsigned OFFSET_W               = 13;
    localparam int unsigned THAI_SB_MAX_LINE_BYTES = 4096;

    // Thai codepoints used by the classifier.
    localparam logic [CP_W-1:0] CP_NUL       = 21'h000000;
    localparam logic [CP_W-1:0] CP_V1_FIRST  = 21'h000E40;
    localparam logic [CP_W-1:0] CP_V1_LAST   = 21'h000E44;
    localparam logic [CP_W-1:0] CP_C1_FIRST  = 21'h000E01;
    localparam logic [CP_W-1:0] CP_C1_LAST   = 21'h000E2E;
    localparam logic [CP_W-1:0] CP_NO_NU     = 21'h000E19;
    localparam logic [CP_W-1:0] CP_MO_MA     = 21'h000E21;
    localparam logic [CP_W-1:0] CP_RO_RUA    = 21'h000E23;
    localparam logic [CP_W-1:0] CP_LO_LING   = 21'h000E25;
    localparam logic [CP_W-1:0] CP_WO_WAEN   = 21'h000E27;
    localparam logic [CP_W-1:0] CP_MAI_HAN   = 21'h000E31;
    localparam logic [CP_W-1:0] CP_SARA_I    = 21'h000E34;
    localparam logic [CP_W-1:0] CP_SARA_UU   = 21'h000E39;
    localparam logic [CP_W-1:0] CP_MAITAIKHU = 21'h000E47;
    localparam logic [CP_W-1:0] CP_T_FIRST   = 21'h000E48;
    localparam logic [CP_W-1:0] CP_T_LAST    = 21'h000E4B;
    localparam logic [CP_W-1:0] CP_YO_YAK    = 21'h000E22;
    localparam logic [CP_W-1:0] CP_O_ANG     = 21'h000E2D;
    localparam logic [CP_W-1:0] CP_SARA_AA   = 21'h000E32;
    localparam logic [CP_W-1:0] CP_KO_KAI    = 21'h000E01;
    localparam logic [CP_W-1:0] CP_NGO_NGU   = 21'h000E07;
    localparam logic [CP_W-1:0] CP_DO_DEK    = 21'h000E14;
    localparam logic [CP_W-1:0] CP_BO_BAI    = 21'h000E1A;

    // Category mask, one bit per category in priority order.
    typedef struct packed {
        logic c1;
        logic v1;
        logic c3;
        logic v3;
        logic t;
        logic v2;
        logic c2;
    } t_cat;

    typedef enum logic [2:0] {
        ST_EXPECT = 3'd0,
        ST_AFT_V1 = 3'd1,
        ST_AFT_C1 = 3'd2,
        ST_AFT_C2 = 3'd3,
        ST_AFT_V2 = 3'd4,
        ST_AFT_T  = 3'd5,
        ST_AFT_V3 = 3'd6
    } t_syl_state;

    typedef enum logic [KIND_W-1:0] {
        KIND_BREAK = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic                has_result;
        t_kind               kind;
        logic [OFFSET_W-1:0] offset;
        logic                line_end;
    } t_decision;

    // Categories that each syllable state lets through.
    function automatic t_cat accepted_cats(input t_syl_state st);
        t_cat m;
        m = '0;
        unique case (st)
            ST_AFT_V1: m.c1 = 1'b1;
            ST_AFT_C1: m = '1;
            ST_AFT_C2: begin
                m.v2 = 1'b1; m.t = 1'b1; m.v3 = 1'b1; m.c3 = 1'b1;
            end
            ST_AFT_V2: begin
                m = '1; m.c2 = 1'b0; m.v2 = 1'b0;
            end
            ST_AFT_T: begin
                m.c1 = 1'b1; m.v1 = 1'b1; m.c3 = 1'b1; m.v3 = 1'b1;
            end
            ST_AFT_V3: begin
                m.c1 = 1'b1; m.v1 = 1'b1; m.c3 = 1'b1;
            end
            default: begin
                m.c1 = 1'b1; m.v1 = 1'b1;
            end
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/thai_sb_in_if.sv @@
// Input channel of the Thai syllable breaker: valid/ready plus one codepoint item.
// Depends on thai_sb_pkg.
interface thai_sb_in_if;
    import thai_sb_pkg::*;

    logic                valid;
    logic                ready;
    logic [CP_W-1:0]     codepoint;
    logic [LEN_W-1:0]    byte_len;
    logic                line_last;

    modport source (output valid, output codepoint, output byte_len, output line_last,
                    input ready);
    modport sink   (input valid, input codepoint, input byte_len, input line_last,
                    output ready);
endinterface

@@ rtl/core/thai_sb_out_if.sv @@
// Result channel of the Thai syllable breaker: valid/ready plus one result item.
// Depends on thai_sb_pkg.
interface thai_sb_out_if;
    import thai_sb_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] offset;
    logic                line_end;

    modport source (output valid, output kind, output offset, output line_end,
                    input ready);
    modport sink   (input valid, input kind, input offset, input line_end,
                    output ready);
endinterface

@@ rtl/core/thai_sb_classify.sv @@
// Codepoint classifier: maps one codepoint to its Thai category mask.
// Depends on thai_sb_pkg.
module thai_sb_classify (
    input  logic [thai_sb_pkg::CP_W-1:0] i_codepoint,
    output thai_sb_pkg::t_cat            o_cats
);
    import thai_sb_pkg::*;

    logic [CP_W-1:0] c;
    assign c = i_codepoint;

    always_comb begin
        o_cats    = '0;
        o_cats.v1 = (c >= CP_V1_FIRST) && (c <= CP_V1_LAST);
        o_cats.c1 = (c >= CP_C1_FIRST) && (c <= CP_C1_LAST);
        o_cats.c2 = (c == CP_NO_NU) || (c == CP_MO_MA) || (c == CP_RO_RUA) ||
                    (c == CP_LO_LING) || (c == CP_WO_WAEN);
        o_cats.v2 = (c == CP_MAI_HAN) || ((c >= CP_SARA_I) && (c <= CP_SARA_UU)) ||
                    (c == CP_MAITAIKHU);
        o_cats.t  = (c >= CP_T_FIRST) && (c <= CP_T_LAST);
        o_cats.v3 = (c == CP_YO_YAK) || (c == CP_WO_WAEN) || (c == CP_O_ANG) ||
                    (c == CP_SARA_AA);
        o_cats.c3 = (c == CP_KO_KAI) || (c == CP_NGO_NGU) || (c == CP_DO_DEK) ||
                    (c == CP_NO_NU) || (c == CP_BO_BAI) || (c == CP_MO_MA) ||
                    (c == CP_YO_YAK) || (c == CP_WO_WAEN);
    end
endmodule

@@ rtl/core/thai_sb_fsm.sv @@
// Syllable state machine: holds syllable state, line byte position and the
// skip flag, and decides the result for the item in the input register.
// Depends on thai_sb_pkg.
module thai_sb_fsm #(
    parameter int unsigned MAX_LINE_BYTES = thai_sb_pkg::THAI_SB_MAX_LINE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [thai_sb_pkg::CP_W-1:0]  i_codepoint,
    input  logic [thai_sb_pkg::LEN_W-1:0] i_byte_len,
    input  logic                          i_line_last,
    input  thai_sb_pkg::t_cat             i_cats,
    output thai_sb_pkg::t_decision        o_dec
);
    import thai_sb_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_LINE_BYTES + 1);
    localparam logic [POS_W:0] MAX_POS = (POS_W + 1)'(MAX_LINE_BYTES);

    t_syl_state       r_state, n_state;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic             r_skip,  n_skip;

    logic [POS_W:0]   w_sum;
    logic [POS_W-1:0] w_end;
    t_cat             w_hit;
    logic             w_mid;

    assign w_sum = {1'b0, r_pos} + (POS_W + 1)'(i_byte_len);
    assign w_end = (w_sum > MAX_POS) ? MAX_POS[POS_W-1:0] : w_sum[POS_W-1:0];
    assign w_hit = i_cats & accepted_cats(r_state);
    assign w_mid = (r_state == ST_AFT_C1) || (r_state == ST_AFT_V2) ||
                   (r_state == ST_AFT_T)  || (r_state == ST_AFT_V3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EXPECT;
            r_pos   <= '0;
            r_skip  <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_pos            = r_pos;
        n_skip           = r_skip;
        o_dec.has_result = 1'b0;
        o_dec.kind       = KIND_BREAK;
        o_dec.offset     = OFFSET_W'(w_end);
        o_dec.line_end   = i_line_last;

        if (r_skip) begin
            // Rest of a line after an error or a NUL: only the line end matters.
        end else if (i_codepoint == CP_NUL) begin
            o_dec.has_result = 1'b1;
            o_dec.kind       = KIND_DONE;
            o_dec.offset     = OFFSET_W'(r_pos);
            n_skip           = 1'b1;
        end else if (w_hit == '0) begin
            o_dec.has_result = 1'b1;
            o_dec.kind       = KIND_ERROR;
            n_skip           = 1'b1;
        end else begin
            n_pos = w_end;
            priority if (w_hit.c2) begin
                n_state = ST_AFT_C2;
            end else if (w_hit.v2) begin
                n_state = ST_AFT_V2;
            end else if (w_hit.t) begin
                n_state = ST_AFT_T;
            end else if (w_hit.v3) begin
                n_state = ST_AFT_V3;
            end else if (w_hit.c3) begin
                n_state          = ST_EXPECT;
                o_dec.has_result = 1'b1;
            end else if (w_hit.v1) begin
                n_state          = ST_AFT_V1;
                o_dec.has_result = w_mid;
                o_dec.offset     = OFFSET_W'(r_pos);
            end else begin
                n_state          = ST_AFT_C1;
                o_dec.has_result = w_mid;
                o_dec.offset     = OFFSET_W'(r_pos);
            end
            // The last item of a line reports done past itself instead of a break.
            if (i_line_last) begin
                o_dec.has_result = 1'b1;
                o_dec.kind       = KIND_DONE;
                o_dec.offset     = OFFSET_W'(w_end);
            end
        end

        if (i_line_last) begin
            n_state = ST_EXPECT;
            n_pos   = '0;
            n_skip  = 1'b0;
        end
    end
endmodule

@@ rtl/core/thai_syllable_breaker.sv @@
// Thai syllable breaker top level: input register, classifier, syllable
// state machine and result register.
// Depends on thai_sb_pkg, thai_sb_in_if, thai_sb_out_if, thai_sb_classify, thai_sb_fsm.
//
// Usage: i_in carries one decoded codepoint per item with its UTF-8 length
// and a last-of-line flag. o_out carries at most one result per item: a
// syllable break, an invalid-character error or a line-done report, each
// with a byte offset and a line-end flag. Items that cause no result simply
// produce nothing on o_out.
// Path: an accepted item sits in the input register and is decided when it
// leaves it; its result then enters the result register and is visible
// on o_out from there on.
// Throughput: one item per cycle while no result waits on a stalled o_out; the
// decide path from the input register to the result register is combinational.
// Reset: i_rst_n (synchronous, active low) clears both valid flags and puts
// the line machine at the start of a syllable with byte position zero.
// Stalls: when o_out.ready is low and a result waits, the input register
// holds its item and i_in.ready stays high only while that register is empty.
module thai_syllable_breaker #(
    parameter int unsigned MAX_LINE_BYTES = thai_sb_pkg::THAI_SB_MAX_LINE_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    thai_sb_in_if.sink    i_in,
    thai_sb_out_if.source o_out
);
    import thai_sb_pkg::*;

    logic                r_in_valid;
    logic [CP_W-1:0]     r_cp;
    logic [LEN_W-1:0]    r_len;
    logic                r_last;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_line_end;

    logic      w_fire;
    t_cat      w_cats;
    t_decision w_dec;

    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cp   <= i_in.codepoint;
            r_len  <= i_in.byte_len;
            r_last <= i_in.line_last;
        end
    end

    thai_sb_classify u_classify (
        .i_codepoint (r_cp),
        .o_cats      (w_cats)
    );

    thai_sb_fsm #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_codepoint (r_cp),
        .i_byte_len  (r_len),
        .i_line_last (r_last),
        .i_cats      (w_cats),
        .o_dec       (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_dec.has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_dec.has_result) begin
            r_kind     <= w_dec.kind;
            r_offset   <= w_dec.offset;
            r_line_end <= w_dec.line_end;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_kind;
    assign o_out.offset   = r_offset;
    assign o_out.line_end = r_line_end;
endmodule

@@ bench/tb_thai_syllable_breaker.sv @@
// Self-checking testbench for thai_syllable_breaker: random and directed codepoint lines,
// a behavioral syllable predictor, and valid/ready idling on both channels.
// Depends on thai_sb_pkg, thai_sb_in_if, thai_sb_out_if and the block itself.
module tb_thai_syllable_breaker;
    timeunit 1ns;
    timeprecision 1ps;

    import thai_sb_pkg::*;

    localparam int unsigned MAX_BYTES    = THAI_SB_MAX_LINE_BYTES;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_ITEMS  = 165;
    localparam int unsigned RANDOM_ITEMS = 660;
    localparam int unsigned SAT_AFTER    = 60;

    // Category bits, in the order the syllable machine tries them.
    localparam logic [6:0] M_C2 = 7'b000_0001;
    localparam logic [6:0] M_V2 = 7'b000_0010;
    localparam logic [6:0] M_T  = 7'b000_0100;
    localparam logic [6:0] M_V3 = 7'b000_1000;
    localparam logic [6:0] M_C3 = 7'b001_0000;
    localparam logic [6:0] M_V1 = 7'b010_0000;
    localparam logic [6:0] M_C1 = 7'b100_0000;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_BREAK_START,
        ACT_BREAK_END,
        ACT_REJECT
    } t_seg_action;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_phase;

    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic [LEN_W-1:0] byte_len;
        logic             line_last;
    } t_cp_item;

    typedef struct packed {
        t_kind               kind;
        logic [OFFSET_W-1:0] offset;
        logic                line_end;
    } t_seg_result;

    logic i_clk;
    logic i_rst_n;

    thai_sb_in_if  in_ch();
    thai_sb_out_if out_ch();

    thai_syllable_breaker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_cp_item        pending_items[$];
    t_seg_result     expected_results[$];
    logic [CP_W-1:0] line_cps[$];
    t_cp_item        cur_item;
    int unsigned     items_sent;
    int unsigned     cycle_count;
    int unsigned     error_count;
    t_idle_phase     idle_phase;

    // Predictor state for the current line.
    t_syl_state  line_state;
    int unsigned line_pos;
    bit          skip_line;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always_comb begin
        idle_phase = t_idle_phase'((items_sent / PHASE_ITEMS) % 4);
    end

    function automatic logic [6:0] cp_categories(input logic [CP_W-1:0] cp);
        logic [6:0] m;
        m = '0;
        if (cp >= CP_V1_FIRST && cp <= CP_V1_LAST) m |= M_V1;
        if (cp >= CP_C1_FIRST && cp <= CP_C1_LAST) m |= M_C1;
        if (cp == CP_NO_NU || cp == CP_MO_MA || cp == CP_RO_RUA || cp == CP_LO_LING ||
            cp == CP_WO_WAEN) m |= M_C2;
        if (cp == CP_MAI_HAN || (cp >= CP_SARA_I && cp <= CP_SARA_UU) || cp == CP_MAITAIKHU)
            m |= M_V2;
        if (cp >= CP_T_FIRST && cp <= CP_T_LAST) m |= M_T;
        if (cp == CP_YO_YAK || cp == CP_WO_WAEN || cp == CP_O_ANG || cp == CP_SARA_AA)
            m |= M_V3;
        if (cp == CP_KO_KAI || cp == CP_NGO_NGU || cp == CP_DO_DEK || cp == CP_NO_NU ||
            cp == CP_BO_BAI || cp == CP_MO_MA || cp == CP_YO_YAK || cp == CP_WO_WAEN)
            m |= M_C3;
        return m;
    endfunction

    function automatic logic [6:0] state_allows(input t_syl_state st);
        case (st)
            ST_AFT_V1: return M_C1;
            ST_AFT_C1: return M_C2 | M_V2 | M_T | M_V3 | M_C3 | M_V1 | M_C1;
            ST_AFT_C2: return M_V2 | M_T | M_V3 | M_C3;
            ST_AFT_V2: return M_T | M_V3 | M_C3 | M_V1 | M_C1;
            ST_AFT_T:  return M_V3 | M_C3 | M_V1 | M_C1;
            ST_AFT_V3: return M_C3 | M_V1 | M_C1;
            default:   return M_V1 | M_C1;
        endcase
    endfunction

    task automatic clear_line();
        line_state = ST_EXPECT;
        line_pos   = 0;
        skip_line  = 1'b0;
    endtask

    task automatic push_result(input t_kind kind, input int unsigned offset, input logic last);
        t_seg_result r;
        r.kind     = kind;
        r.offset   = offset[OFFSET_W-1:0];
        r.line_end = last;
        expected_results = {expected_results, r};
    endtask

    // Advances the line model by one accepted codepoint and queues its result, if any.
    task automatic predict_segment(input t_cp_item it);
        logic [6:0]  hit;
        int unsigned start_pos;
        int unsigned end_pos;
        t_syl_state  nxt;
        t_seg_action act;
        bit          mid;
        start_pos = line_pos;
        end_pos   = line_pos + it.byte_len;
        if (end_pos > MAX_BYTES) end_pos = MAX_BYTES;
        mid = (line_state == ST_AFT_C1 || line_state == ST_AFT_V2 ||
               line_state == ST_AFT_T  || line_state == ST_AFT_V3);
        nxt = ST_EXPECT;
        act = ACT_REJECT;
        if (skip_line) begin
            if (it.line_last) clear_line();
            return;
        end
        // A zero codepoint stops the scan at its start and skips the rest of the line.
        if (it.codepoint == CP_NUL) begin
            push_result(KIND_DONE, start_pos, it.line_last);
            if (it.line_last) clear_line();
            else skip_line = 1'b1;
            return;
        end
        hit = cp_categories(it.codepoint) & state_allows(line_state);
        if (hit & M_C2)      begin nxt = ST_AFT_C2; act = ACT_NONE; end
        else if (hit & M_V2) begin nxt = ST_AFT_V2; act = ACT_NONE; end
        else if (hit & M_T)  begin nxt = ST_AFT_T;  act = ACT_NONE; end
        else if (hit & M_V3) begin nxt = ST_AFT_V3; act = ACT_NONE; end
        else if (hit & M_C3) begin nxt = ST_EXPECT; act = ACT_BREAK_END; end
        else if (hit & M_V1) begin
            nxt = ST_AFT_V1;
            act = mid ? ACT_BREAK_START : ACT_NONE;
        end else if (hit & M_C1) begin
            nxt = ST_AFT_C1;
            act = mid ? ACT_BREAK_START : ACT_NONE;
        end
        if (act == ACT_REJECT) begin
            push_result(KIND_ERROR, end_pos, it.line_last);
            if (it.line_last) clear_line();
            else skip_line = 1'b1;
            return;
        end
        line_pos   = end_pos;
        line_state = nxt;
        if (it.line_last) begin
            push_result(KIND_DONE, end_pos, 1'b1);
            clear_line();
        end else if (act == ACT_BREAK_START) begin
            push_result(KIND_BREAK, start_pos, 1'b0);
        end else if (act == ACT_BREAK_END) begin
            push_result(KIND_BREAK, end_pos, 1'b0);
        end
    endtask

    task automatic queue_item(input logic [CP_W-1:0] cp, input int unsigned len,
                              input logic last);
        t_cp_item it;
        it.codepoint = cp;
        it.byte_len  = len[LEN_W-1:0];
        it.line_last = last;
        pending_items = {pending_items, it};
    endtask

    task automatic append_cp(input logic [CP_W-1:0] cp);
        line_cps = {line_cps, cp};
    endtask

    function automatic logic [CP_W-1:0] random_cp();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)  return CP_NUL;
        if (r < 60) return CP_W'(21'h000E00 + $urandom_range(0, 'h5F));
        if (r < 80) return CP_W'($urandom_range(0, 'h10FFFF));
        return CP_W'($urandom_range('h20, 'h7E));
    endfunction

    function automatic int unsigned random_len();
        if ($urandom_range(0, 99) < 85) return 3;
        return $urandom_range(0, 7);
    endfunction

    function automatic bit idle_now(input bit sender_side);
        int unsigned pct;
        case (idle_phase)
            IDLE_SENDER:   pct = sender_side ? 58 : 0;
            IDLE_RECEIVER: pct = sender_side ? 0 : 58;
            IDLE_BOTH:     pct = 25;
            default:       pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // Driver: presents the next pending item and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_segment(cur_item);
                items_sent <= items_sent + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_items.size() > 0 && !idle_now(1'b1)) begin
                    cur_item = pending_items.pop_front();
                    in_ch.codepoint <= cur_item.codepoint;
                    in_ch.byte_len  <= cur_item.byte_len;
                    in_ch.line_last <= cur_item.line_last;
                    in_ch.valid     <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_seg_result exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    error_count <= error_count + 1;
                    $display("%0t: unexpected result kind=%0d offset=%0d line_end=%0d",
                             $time, out_ch.kind, out_ch.offset, out_ch.line_end);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.kind !== exp_r.kind || out_ch.offset !== exp_r.offset ||
                        out_ch.line_end !== exp_r.line_end) begin
                        error_count <= error_count + 1;
                        $display("%0t: mismatch expected kind=%0d offset=%0d line_end=%0d, %s",
                                 $time, exp_r.kind, exp_r.offset, exp_r.line_end,
                                 $sformatf("actual kind=%0d offset=%0d line_end=%0d",
                                           out_ch.kind, out_ch.offset, out_ch.line_end));
                    end
                end
            end
            out_ch.ready <= !idle_now(1'b0);
        end
    end

    initial begin
        int unsigned n_syl;
        int unsigned sat_bytes;
        in_ch.valid     = 1'b0;
        in_ch.codepoint = '0;
        in_ch.byte_len  = '0;
        in_ch.line_last = 1'b0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        items_sent      = 0;
        cycle_count     = 0;
        error_count     = 0;
        sat_bytes       = 0;
        clear_line();

        // Directed line walking every state, with a break before a new syllable from
        // AFT_C1, AFT_V2 and AFT_T, a break after a final consonant and a clean line end.
        queue_item(CP_V1_FIRST, 3, 1'b0);
        queue_item(CP_KO_KAI, 3, 1'b0);
        queue_item(CP_RO_RUA, 3, 1'b0);
        queue_item(CP_SARA_I, 3, 1'b0);
        queue_item(CP_T_FIRST, 3, 1'b0);
        queue_item(CP_SARA_AA, 3, 1'b0);
        queue_item(CP_NGO_NGU, 3, 1'b0);
        queue_item(CP_C1_FIRST + 21'd1, 3, 1'b0);
        queue_item(CP_V1_LAST, 3, 1'b0);
        queue_item(CP_C1_FIRST + 21'd2, 3, 1'b0);
        queue_item(CP_MAI_HAN, 3, 1'b0);
        queue_item(CP_C1_FIRST + 21'd3, 3, 1'b0);
        queue_item(CP_T_LAST, 3, 1'b0);
        queue_item(CP_C1_FIRST + 21'd4, 3, 1'b0);
        queue_item(CP_O_ANG, 3, 1'b0);
        queue_item(CP_C1_LAST, 3, 1'b1);
        // Odd byte lengths, an out of range codepoint and the skip to line end.
        queue_item(CP_KO_KAI, 0, 1'b0);
        queue_item(CP_MAITAIKHU, 7, 1'b0);
        queue_item(21'h10FFFF, 4, 1'b0);
        queue_item(CP_KO_KAI, 3, 1'b0);
        queue_item(CP_KO_KAI, 3, 1'b1);
        // Zero codepoint in mid line and as a whole line, then an error on the last item.
        queue_item(CP_KO_KAI, 3, 1'b0);
        queue_item(CP_NUL, 1, 1'b0);
        queue_item(CP_KO_KAI, 3, 1'b1);
        queue_item(CP_NUL, 1, 1'b1);
        queue_item(21'h000041, 1, 1'b1);

        while (pending_items.size() < RANDOM_ITEMS) begin
            line_cps.delete();
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 8)) append_cp(random_cp());
            end else begin
                n_syl = $urandom_range(1, 8);
                repeat (n_syl) begin
                    if ($urandom_range(0, 9) < 3)
                        append_cp(CP_W'(CP_V1_FIRST + $urandom_range(0, 4)));
                    append_cp(CP_W'(CP_C1_FIRST + $urandom_range(0, 'h2D)));
                    if ($urandom_range(0, 9) < 3) begin
                        case ($urandom_range(0, 4))
                            0: append_cp(CP_NO_NU);
                            1: append_cp(CP_MO_MA);
                            2: append_cp(CP_RO_RUA);
                            3: append_cp(CP_LO_LING);
                            default: append_cp(CP_WO_WAEN);
                        endcase
                    end
                    if ($urandom_range(0, 9) < 4) begin
                        case ($urandom_range(0, 2))
                            0: append_cp(CP_MAI_HAN);
                            1: append_cp(CP_MAITAIKHU);
                            default: append_cp(CP_W'(CP_SARA_I + $urandom_range(0, 5)));
                        endcase
                    end
                    if ($urandom_range(0, 9) < 4)
                        append_cp(CP_W'(CP_T_FIRST + $urandom_range(0, 3)));
                    if ($urandom_range(0, 9) < 3) begin
                        case ($urandom_range(0, 3))
                            0: append_cp(CP_YO_YAK);
                            1: append_cp(CP_WO_WAEN);
                            2: append_cp(CP_O_ANG);
                            default: append_cp(CP_SARA_AA);
                        endcase
                    end
                    if ($urandom_range(0, 9) < 3) begin
                        case ($urandom_range(0, 7))
                            0: append_cp(CP_KO_KAI);
                            1: append_cp(CP_NGO_NGU);
                            2: append_cp(CP_DO_DEK);
                            3: append_cp(CP_NO_NU);
                            4: append_cp(CP_BO_BAI);
                            5: append_cp(CP_MO_MA);
                            6: append_cp(CP_YO_YAK);
                            default: append_cp(CP_WO_WAEN);
                        endcase
                    end
                    if ($urandom_range(0, 9) == 0) append_cp(random_cp());
                end
            end
            foreach (line_cps[i])
                queue_item(line_cps[i], random_len(), i == line_cps.size() - 1);

            // One long line of consonant plus sara aa pairs runs the position into
            // saturation. The consonants are plain ones, never finals, so each new
            // consonant opens a syllable and the line never errors out.
            if (sat_bytes == 0 && pending_items.size() > SAT_AFTER) begin
                while (sat_bytes < MAX_BYTES + 100) begin
                    queue_item(CP_W'(CP_C1_FIRST + $urandom_range(1, 5)), 7, 1'b0);
                    queue_item(CP_SARA_AA, 7, 1'b0);
                    sat_bytes += 14;
                end
                queue_item(CP_W'(CP_C1_FIRST + $urandom_range(1, 5)), 7, 1'b1);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0) &&
               cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still expected", $time,
                     expected_results.size());
            error_count = error_count + 1;
        end
        if (error_count == 0) begin
            $display("tb_thai_syllable_breaker passed");
        end else begin
            $display("tb_thai_syllable_breaker failed");
        end
        $finish;
    end

endmodule
